// ===== sv/rjpc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rjpc_pkg;

  // field widths of the request and result items
  localparam int LABEL_W    = 8;
  localparam int COUNT_W    = 19;
  localparam int FRAC_W     = 16;
  localparam int RATIO_W    = FRAC_W + 1;

  // default sizing of the point store
  localparam int MAX_POINTS_DEF = 1024;
  localparam int LABEL_BITS_DEF = 8;

  // one input request
  typedef struct packed {
    logic [LABEL_W-1:0] predicted_label;
    logic [LABEL_W-1:0] true_label;
    logic               last_point;
  } in_data_t;

  // one result
  typedef struct packed {
    logic [COUNT_W-1:0] true_positive;
    logic [COUNT_W-1:0] false_negative;
    logic [COUNT_W-1:0] false_positive;
    logic [COUNT_W-1:0] true_negative;
    logic [RATIO_W-1:0] rand_index;
    logic [RATIO_W-1:0] jaccard_index;
    logic               rand_undefined;
    logic               jaccard_undefined;
    logic               capacity_overflow;
  } out_data_t;

  // control broadcast to every cell of the store
  typedef struct packed {
    logic rotate;
    logic insert;
  } cell_ctrl_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_INSERT,
    ST_RAND_GO,
    ST_RAND_WAIT,
    ST_JAC_GO,
    ST_JAC_WAIT,
    ST_LOAD
  } state_t;

endpackage

`default_nettype wire

// ===== sv/rjpc_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rjpc_cell #(
  parameter int LABEL_BITS = rjpc_pkg::LABEL_BITS_DEF
) (
  input  wire                    clk,
  input  rjpc_pkg::cell_ctrl_t   ctrl,
  input  wire                    tok_here,
  input  wire                    tok_next,
  input  wire [LABEL_BITS-1:0]   head_pred,
  input  wire [LABEL_BITS-1:0]   head_true,
  input  wire [LABEL_BITS-1:0]   next_pred,
  input  wire [LABEL_BITS-1:0]   next_true,
  input  wire [LABEL_BITS-1:0]   query_pred,
  input  wire [LABEL_BITS-1:0]   query_true,
  output logic [LABEL_BITS-1:0]  pred,
  output logic [LABEL_BITS-1:0]  truth
);

  logic [LABEL_BITS-1:0] pred_r;
  logic [LABEL_BITS-1:0] truth_r;

  // ring rotation: each cell takes the next cell's point and the head wraps around to
  // the last occupied cell; on insert, the free slot marked by the token takes a new point
  always_ff @(posedge clk) begin
    if (ctrl.rotate) begin
      pred_r  <= tok_next ? head_pred : next_pred;
      truth_r <= tok_next ? head_true : next_true;
    end else if (ctrl.insert && tok_here) begin
      pred_r  <= query_pred;
      truth_r <= query_true;
    end
  end

  assign pred  = pred_r;
  assign truth = truth_r;

endmodule

`default_nettype wire

// ===== sv/rjpc_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rjpc_div #(
  parameter int CNT_W = rjpc_pkg::COUNT_W
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             start,
  input  wire [CNT_W-1:0]                 num,
  input  wire [CNT_W-1:0]                 den,
  output logic                            done,
  output logic [rjpc_pkg::RATIO_W-1:0]    quotient
);

  localparam int DW  = CNT_W + rjpc_pkg::RATIO_W;
  localparam int CW  = $clog2(DW + 1);

  logic [DW-1:0]                  dvd_r;
  logic [CNT_W-1:0]               rem_r;
  logic [CNT_W-1:0]               den_r;
  logic [rjpc_pkg::RATIO_W-1:0]   quo_r;
  logic [CW-1:0]                  cnt_r;
  logic                           busy_r;
  logic                           done_r;

  logic [CNT_W:0]                 trial;
  logic [CNT_W:0]                 diff;
  logic                           fits;

  // one quotient bit per cycle, restoring long division
  assign trial = {rem_r, dvd_r[DW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = trial >= {1'b0, den_r};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // datapath, dividend is num * 2^16 plus half the divisor for rounding
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= DW'({num, {rjpc_pkg::FRAC_W{1'b0}}}) + DW'(den >> 1);
      rem_r <= '0;
      den_r <= den;
      quo_r <= '0;
      cnt_r <= CW'(DW);
    end else if (busy_r) begin
      dvd_r <= dvd_r << 1;
      rem_r <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      quo_r <= {quo_r[rjpc_pkg::RATIO_W-2:0], fits};
      cnt_r <= cnt_r - CW'(1);
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// ===== sv/rand_jaccard_pair_counter_core.sv =====
// Pair-counting Rand index and Jaccard coefficient.
// Input channel (in_valid / in_stall / in_data): one point per request, a
// predicted and a true label plus a last mark. Each point is compared with
// every point stored before it in the current data set and the pair counts
// (TP, FN, FP, TN) are updated. Result channel (out_valid / out_stall /
// out_data): one result per data set, after the point marked last.
// A new point is taken only after the previous one is inserted; the
// stored points circulate once around the cell ring past a single
// comparator, one point per cycle. Points beyond the store capacity are
// dropped at once and flagged.
// After the last point, the Rand and then the Jaccard ratio are computed
// by two serial divisions on the shared divider.
// The result waits in an output register; further points are taken while
// the receiver stalls, but the next result waits until that register frees.
// Reset (rst_n low, synchronous) empties the store and clears the pair counters and overflow flag.
`timescale 1ns / 1ps
`default_nettype none

module rand_jaccard_pair_counter_core #(
  parameter int MAX_POINTS = rjpc_pkg::MAX_POINTS_DEF,
  parameter int LABEL_BITS = rjpc_pkg::LABEL_BITS_DEF
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  rjpc_pkg::in_data_t    in_data,
  output logic                  out_valid,
  input  wire                   out_stall,
  output rjpc_pkg::out_data_t   out_data
);

  localparam int CNT_W = 2 * $clog2(MAX_POINTS) - 1;
  localparam int PC_W  = $clog2(MAX_POINTS + 1);

  rjpc_pkg::state_t      state_r;
  rjpc_pkg::state_t      state_nxt;
  rjpc_pkg::cell_ctrl_t  ctrl;

  logic [LABEL_BITS-1:0] q_pred_r;
  logic [LABEL_BITS-1:0] q_true_r;
  logic                  q_last_r;

  logic [PC_W-1:0]       point_count_r;
  logic [PC_W-1:0]       scan_cnt_r;
  logic [MAX_POINTS:0]   tail_r;
  logic                  overflow_r;

  logic [CNT_W-1:0]      tp_r;
  logic [CNT_W-1:0]      fn_r;
  logic [CNT_W-1:0]      fp_r;
  logic [CNT_W-1:0]      tn_r;
  logic [CNT_W-1:0]      agree_r;
  logic [CNT_W-1:0]      jden_r;
  logic [CNT_W-1:0]      pairs_r;

  logic [rjpc_pkg::RATIO_W-1:0] rand_q_r;

  logic                  out_valid_r;
  rjpc_pkg::out_data_t   out_data_r;

  logic [LABEL_BITS-1:0] cell_pred [MAX_POINTS];
  logic [LABEL_BITS-1:0] cell_true [MAX_POINTS];

  logic                  accept;
  logic                  full;
  logic                  same_p;
  logic                  same_t;
  logic                  div_start;
  logic [CNT_W-1:0]      div_num;
  logic [CNT_W-1:0]      div_den;
  logic                  div_done;
  logic [rjpc_pkg::RATIO_W-1:0] div_q;
  logic                  out_free;

  assign accept   = in_valid && !in_stall;
  assign full     = point_count_r == PC_W'(MAX_POINTS);
  assign same_p   = cell_pred[0] == q_pred_r;
  assign same_t   = cell_true[0] == q_true_r;
  assign out_free = !out_valid_r || !out_stall;

  // ring of point cells; the tail token marks the next free cell
  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    if (i == MAX_POINTS - 1) begin : g_end
      rjpc_cell #(.LABEL_BITS(LABEL_BITS)) u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .tok_here   (tail_r[i]),
        .tok_next   (tail_r[i+1]),
        .head_pred  (cell_pred[0]),
        .head_true  (cell_true[0]),
        .next_pred  (cell_pred[0]),
        .next_true  (cell_true[0]),
        .query_pred (q_pred_r),
        .query_true (q_true_r),
        .pred       (cell_pred[i]),
        .truth      (cell_true[i])
      );
    end else begin : g_mid
      rjpc_cell #(.LABEL_BITS(LABEL_BITS)) u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .tok_here   (tail_r[i]),
        .tok_next   (tail_r[i+1]),
        .head_pred  (cell_pred[0]),
        .head_true  (cell_true[0]),
        .next_pred  (cell_pred[i+1]),
        .next_true  (cell_true[i+1]),
        .query_pred (q_pred_r),
        .query_true (q_true_r),
        .pred       (cell_pred[i]),
        .truth      (cell_true[i])
      );
    end
  end

  // shared serial divider for both ratios
  rjpc_div #(.CNT_W(CNT_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .num      (div_num),
    .den      (div_den),
    .done     (div_done),
    .quotient (div_q)
  );

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rjpc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and control
  always_comb begin
    state_nxt   = state_r;
    in_stall    = 1'b1;
    ctrl.rotate = 1'b0;
    ctrl.insert = 1'b0;
    div_start   = 1'b0;
    div_num     = agree_r;
    div_den     = pairs_r;
    unique case (state_r)
      rjpc_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (point_count_r == PC_W'(MAX_POINTS)) begin
            state_nxt = in_data.last_point ? rjpc_pkg::ST_RAND_GO : rjpc_pkg::ST_IDLE;
          end else if (point_count_r == '0) begin
            state_nxt = rjpc_pkg::ST_INSERT;
          end else begin
            state_nxt = rjpc_pkg::ST_SCAN;
          end
        end
      end
      rjpc_pkg::ST_SCAN: begin
        ctrl.rotate = 1'b1;
        if (PC_W'(scan_cnt_r + PC_W'(1)) == point_count_r) begin
          state_nxt = rjpc_pkg::ST_INSERT;
        end
      end
      rjpc_pkg::ST_INSERT: begin
        ctrl.insert = 1'b1;
        state_nxt   = q_last_r ? rjpc_pkg::ST_RAND_GO : rjpc_pkg::ST_IDLE;
      end
      rjpc_pkg::ST_RAND_GO: begin
        div_start = 1'b1;
        state_nxt = rjpc_pkg::ST_RAND_WAIT;
      end
      rjpc_pkg::ST_RAND_WAIT: begin
        if (div_done) begin
          state_nxt = rjpc_pkg::ST_JAC_GO;
        end
      end
      rjpc_pkg::ST_JAC_GO: begin
        div_start = 1'b1;
        div_num   = tp_r;
        div_den   = jden_r;
        state_nxt = rjpc_pkg::ST_JAC_WAIT;
      end
      rjpc_pkg::ST_JAC_WAIT: begin
        if (div_done) begin
          state_nxt = rjpc_pkg::ST_LOAD;
        end
      end
      rjpc_pkg::ST_LOAD: begin
        if (out_free) begin
          state_nxt = rjpc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rjpc_pkg::ST_IDLE;
      end
    endcase
  end

  // latch the request
  always_ff @(posedge clk) begin
    if (accept) begin
      q_pred_r <= LABEL_BITS'(in_data.predicted_label);
      q_true_r <= LABEL_BITS'(in_data.true_label);
      q_last_r <= in_data.last_point;
    end
  end

  // scan position within the ring
  always_ff @(posedge clk) begin
    if (accept) begin
      scan_cnt_r <= '0;
    end else if (state_r == rjpc_pkg::ST_SCAN) begin
      scan_cnt_r <= PC_W'(scan_cnt_r + PC_W'(1));
    end
  end

  // store occupancy, overflow and pair counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= '0;
      tail_r        <= (MAX_POINTS + 1)'(1);
      overflow_r    <= 1'b0;
      tp_r          <= '0;
      fn_r          <= '0;
      fp_r          <= '0;
      tn_r          <= '0;
      agree_r       <= '0;
      jden_r        <= '0;
      pairs_r       <= '0;
    end else if (state_r == rjpc_pkg::ST_LOAD && out_free) begin
      point_count_r <= '0;
      tail_r        <= (MAX_POINTS + 1)'(1);
      overflow_r    <= 1'b0;
      tp_r          <= '0;
      fn_r          <= '0;
      fp_r          <= '0;
      tn_r          <= '0;
      agree_r       <= '0;
      jden_r        <= '0;
      pairs_r       <= '0;
    end else begin
      if (accept && full) begin
        overflow_r <= 1'b1;
      end
      if (state_r == rjpc_pkg::ST_INSERT) begin
        point_count_r <= PC_W'(point_count_r + PC_W'(1));
        tail_r        <= tail_r << 1;
      end
      // classify the pair at the head of the ring
      if (state_r == rjpc_pkg::ST_SCAN) begin
        pairs_r <= pairs_r + CNT_W'(1);
        if (same_p && same_t) begin
          tp_r    <= tp_r + CNT_W'(1);
          agree_r <= agree_r + CNT_W'(1);
          jden_r  <= jden_r + CNT_W'(1);
        end else if (same_t) begin
          fn_r    <= fn_r + CNT_W'(1);
          jden_r  <= jden_r + CNT_W'(1);
        end else if (same_p) begin
          fp_r    <= fp_r + CNT_W'(1);
          jden_r  <= jden_r + CNT_W'(1);
        end else begin
          tn_r    <= tn_r + CNT_W'(1);
          agree_r <= agree_r + CNT_W'(1);
        end
      end
    end
  end

  // rand ratio held while the jaccard ratio is computed
  always_ff @(posedge clk) begin
    if (state_r == rjpc_pkg::ST_RAND_WAIT && div_done) begin
      rand_q_r <= div_q;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == rjpc_pkg::ST_LOAD && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == rjpc_pkg::ST_LOAD && out_free) begin
      out_data_r.true_positive     <= rjpc_pkg::COUNT_W'(tp_r);
      out_data_r.false_negative    <= rjpc_pkg::COUNT_W'(fn_r);
      out_data_r.false_positive    <= rjpc_pkg::COUNT_W'(fp_r);
      out_data_r.true_negative     <= rjpc_pkg::COUNT_W'(tn_r);
      out_data_r.rand_index        <= (pairs_r == '0) ? '0 : rand_q_r;
      out_data_r.jaccard_index     <= (jden_r == '0) ? '0 : div_q;
      out_data_r.rand_undefined    <= pairs_r == '0;
      out_data_r.jaccard_undefined <= jden_r == '0;
      out_data_r.capacity_overflow <= overflow_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  // exactly one free-slot token in the ring
  a_tail_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(tail_r))
    else $error("tail token not one-hot");

  // the store never holds more than its capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    point_count_r <= PC_W'(MAX_POINTS))
    else $error("point count beyond capacity");

  // every pair lands in exactly one class
  a_pairs_sum: assert property (@(posedge clk) disable iff (!rst_n)
    pairs_r == CNT_W'(tp_r + fn_r + fp_r + tn_r) && jden_r == CNT_W'(tp_r + fn_r + fp_r))
    else $error("pair counters disagree");

  // a new result only comes out of the load state
  a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == rjpc_pkg::ST_LOAD))
    else $error("result without load");

  // the ring rotates only while points are stored and the store is not full
  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rjpc_pkg::ST_SCAN |-> point_count_r != '0 && !full)
    else $error("scan with empty or full store");
`endif

endmodule

`default_nettype wire
